FILE: hw/rtl/pps_pkg.sv
// Package of the preemptive priority scheduler: sizes, slot entry layout,
// result status codes, controller states and the select control bundle.
// No dependencies.
package pps_pkg;

  localparam int NumSlots = 8;
  localparam int TimeBits = 16;
  localparam int PrioBits = 8;
  localparam int IdxW     = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  // One task slot as it is kept in the slot memory.
  typedef struct packed {
    logic [TimeBits-1:0] arrival;
    logic [TimeBits-1:0] burst;
    logic [PrioBits-1:0] prio;
    logic [TimeBits-1:0] remaining;
  } entry_t;

  typedef enum logic [1:0] {
    StAdmitted = 2'd0,
    StRejected = 2'd1,
    StRan      = 2'd2,
    StIdleTick = 2'd3
  } status_e;

  typedef enum logic {
    KindAdmit = 1'b0,
    KindTick  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    StateIdle,
    StateScan,
    StateLast,
    StateDecide,
    StateTat,
    StateWait,
    StateEmit
  } state_e;

  // Control from the sequencer to the select unit.
  typedef struct packed {
    logic            clear;
    logic            valid;
    logic [IdxW-1:0] slot;
    logic            busy;
  } sel_ctl_t;

endpackage

FILE: hw/rtl/pps_select.sv
// Running minimum over the slot entries read one per cycle from the slot memory.
// Depends on pps_pkg.
module pps_select (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pps_pkg::sel_ctl_t            ctl_i,
  input  pps_pkg::entry_t              entry_i,
  input  logic [pps_pkg::TimeBits-1:0] time_i,
  output logic                         found_o,
  output logic [pps_pkg::IdxW-1:0]     best_slot_o,
  output pps_pkg::entry_t              best_entry_o
);

  logic                     found_q, found_d;
  logic [pps_pkg::IdxW-1:0] best_slot_q;
  pps_pkg::entry_t          best_entry_q;
  logic                     ready;
  logic                     better;
  logic                     take;

  // A task is ready when its slot is busy and it has already arrived.
  assign ready  = ctl_i.busy && (entry_i.arrival <= time_i);
  // Strictly better only, so the lower slot keeps a full tie.
  assign better = !found_q ||
                  (entry_i.prio < best_entry_q.prio) ||
                  ((entry_i.prio == best_entry_q.prio) &&
                   (entry_i.arrival < best_entry_q.arrival));
  assign take   = ctl_i.valid && ready && better;

  always_comb begin
    found_d = found_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctl_i.clear) begin
      best_slot_q  <= ctl_i.slot;
      best_entry_q <= entry_i;
    end
  end

  assign found_o      = found_q;
  assign best_slot_o  = best_slot_q;
  assign best_entry_o = best_entry_q;

endmodule

FILE: hw/rtl/preemptive_priority_scheduler_unit.sv
// Top level of the preemptive priority scheduler: slot memory, busy flags,
// time counter, sequencer and result register. Depends on pps_pkg, pps_select.
//
// Usage: one input channel (in_valid_i / in_stall_o) carries item beats, one
// output channel (out_valid_o / out_stall_i) returns exactly one result beat
// per item. An admit beat writes a task into a free slot of the slot memory;
// a tick beat runs the ready task with the smallest priority value for one
// time unit and advances the time counter.
// Sequencing: an admit beat goes from acceptance to the emit step before the
// next beat can be accepted. A tick beat scans the slot memory one slot per
// cycle through its single read port and a shared comparator, then passes the
// last and decide steps; when the task finishes, turnaround and waiting time
// are then computed one subtraction per cycle in the Tat and Wait steps.
// The result is staged and moved into the output register; a new beat is
// accepted while a previous result still waits there.
// Reset: all slots are free (busy flags cleared) and time is zero; the slot
// memory itself is not cleared, a slot's contents are only used while busy.
// Stall: while the receiver stalls, the output register holds its beat; a
// finished item then waits in its last step and in_stall_o stays high.
module preemptive_priority_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [2:0]  slot_i,
  input  logic [15:0] arrival_time_i,
  input  logic [15:0] burst_time_i,
  input  logic [7:0]  priority_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  run_slot_o,
  output logic        finished_o,
  output logic [15:0] completion_time_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] waiting_o,
  output logic [15:0] now_o
);

  localparam int TW = pps_pkg::TimeBits;
  localparam int IW = pps_pkg::IdxW;

  // Slot memory: one write port, one registered read port.
  pps_pkg::entry_t mem [pps_pkg::NumSlots];
  pps_pkg::entry_t rdata_q;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  pps_pkg::entry_t mem_wdata;

  pps_pkg::state_e             state_q, state_d;
  logic [IW-1:0]               cnt_q, cnt_d;
  logic                        cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]               cmp_slot_q;
  logic [pps_pkg::NumSlots-1:0] busy_q, busy_d;
  logic [TW-1:0]               time_q, time_d;
  logic                        out_valid_q, out_valid_d;

  // Staged result, moved into the output register in the emit step.
  logic [1:0]    res_status_q, res_status_d;
  logic [IW-1:0] res_slot_q, res_slot_d;
  logic          res_fin_q, res_fin_d;
  logic [TW-1:0] res_ct_q, res_ct_d;
  logic [TW-1:0] res_tat_q, res_tat_d;
  logic [TW-1:0] res_wt_q, res_wt_d;
  logic          res_load;

  logic [1:0]  out_status_q;
  logic [2:0]  out_slot_q;
  logic        out_fin_q;
  logic [15:0] out_ct_q, out_tat_q, out_wt_q, out_now_q;
  logic        out_load;

  pps_pkg::sel_ctl_t sel_ctl;
  logic              found;
  logic [IW-1:0]     best_slot;
  pps_pkg::entry_t   best_entry;

  logic            accept;
  logic [IW-1:0]   admit_idx;
  pps_pkg::entry_t admit_entry;
  logic            admit_bad;
  logic [TW-1:0]   new_rem;

  assign accept    = in_valid_i && !in_stall_o;
  assign admit_idx = IW'(slot_i);

  always_comb begin
    admit_entry.arrival   = TW'(arrival_time_i);
    admit_entry.burst     = TW'(burst_time_i);
    admit_entry.prio      = pps_pkg::PrioBits'(priority_value_i);
    admit_entry.remaining = TW'(burst_time_i);
  end

  // Reject a slot out of range, a zero burst or a slot that is still busy.
  always_comb begin
    admit_bad = 1'b0;
    if (int'(slot_i) >= pps_pkg::NumSlots) begin
      admit_bad = 1'b1;
    end else if (admit_entry.burst == '0) begin
      admit_bad = 1'b1;
    end else if (busy_q[admit_idx]) begin
      admit_bad = 1'b1;
    end
  end

  assign new_rem = best_entry.remaining - TW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[cnt_q];
  end

  always_comb begin
    sel_ctl.clear = accept;
    sel_ctl.valid = cmp_vld_q;
    sel_ctl.slot  = cmp_slot_q;
    sel_ctl.busy  = busy_q[cmp_slot_q];
  end

  pps_select u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (sel_ctl),
    .entry_i      (rdata_q),
    .time_i       (time_q),
    .found_o      (found),
    .best_slot_o  (best_slot),
    .best_entry_o (best_entry)
  );

  assign out_load = (state_q == pps_pkg::StateEmit) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmp_vld_d    = 1'b0;
    busy_d       = busy_q;
    time_d       = time_q;
    mem_we       = 1'b0;
    mem_waddr    = admit_idx;
    mem_wdata    = admit_entry;
    res_load     = 1'b0;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_fin_d    = res_fin_q;
    res_ct_d     = res_ct_q;
    res_tat_d    = res_tat_q;
    res_wt_d     = res_wt_q;
    in_stall_o   = (state_q != pps_pkg::StateIdle);

    case (state_q)
      pps_pkg::StateIdle: begin
        if (accept) begin
          res_load   = 1'b1;
          res_slot_d = '0;
          res_fin_d  = 1'b0;
          res_ct_d   = '0;
          res_tat_d  = '0;
          res_wt_d   = '0;
          if (kind_i == pps_pkg::KindTick) begin
            cnt_d   = '0;
            state_d = pps_pkg::StateScan;
          end else begin
            state_d = pps_pkg::StateEmit;
            if (admit_bad) begin
              res_status_d = pps_pkg::StRejected;
            end else begin
              res_status_d      = pps_pkg::StAdmitted;
              mem_we            = 1'b1;
              busy_d[admit_idx] = 1'b1;
            end
          end
        end
      end
      pps_pkg::StateScan: begin
        // The read of slot cnt_q is under way; compare it next cycle.
        cmp_vld_d = 1'b1;
        if (cnt_q == IW'(pps_pkg::NumSlots - 1)) begin
          state_d = pps_pkg::StateLast;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      pps_pkg::StateLast: begin
        state_d = pps_pkg::StateDecide;
      end
      pps_pkg::StateDecide: begin
        res_load = 1'b1;
        if (time_q != '1) begin
          time_d = time_q + TW'(1);
        end
        if (!found) begin
          res_status_d = pps_pkg::StIdleTick;
          state_d      = pps_pkg::StateEmit;
        end else begin
          res_status_d        = pps_pkg::StRan;
          res_slot_d          = best_slot;
          mem_we              = 1'b1;
          mem_waddr           = best_slot;
          mem_wdata           = best_entry;
          mem_wdata.remaining = new_rem;
          if (new_rem == '0) begin
            busy_d[best_slot] = 1'b0;
            res_fin_d         = 1'b1;
            res_ct_d          = time_d;
            state_d           = pps_pkg::StateTat;
          end else begin
            state_d = pps_pkg::StateEmit;
          end
        end
      end
      pps_pkg::StateTat: begin
        res_load  = 1'b1;
        res_tat_d = (res_ct_q >= best_entry.arrival) ? res_ct_q - best_entry.arrival : '0;
        state_d   = pps_pkg::StateWait;
      end
      pps_pkg::StateWait: begin
        res_load = 1'b1;
        res_wt_d = (res_tat_q >= best_entry.burst) ? res_tat_q - best_entry.burst : '0;
        state_d  = pps_pkg::StateEmit;
      end
      pps_pkg::StateEmit: begin
        if (out_load) begin
          state_d = pps_pkg::StateIdle;
        end
      end
      default: begin
        state_d = pps_pkg::StateIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pps_pkg::StateIdle;
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      busy_q      <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      busy_q      <= busy_d;
      time_q      <= time_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_slot_q <= cnt_q;
    if (res_load) begin
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_fin_q    <= res_fin_d;
      res_ct_q     <= res_ct_d;
      res_tat_q    <= res_tat_d;
      res_wt_q     <= res_wt_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= 3'(res_slot_q);
      out_fin_q    <= res_fin_q;
      out_ct_q     <= 16'(res_ct_q);
      out_tat_q    <= 16'(res_tat_q);
      out_wt_q     <= 16'(res_wt_q);
      out_now_q    <= 16'(time_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign run_slot_o        = out_slot_q;
  assign finished_o        = out_fin_q;
  assign completion_time_o = out_ct_q;
  assign turnaround_o      = out_tat_q;
  assign waiting_o         = out_wt_q;
  assign now_o             = out_now_q;

endmodule
